/* rtl/lph_pkg.sv */
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants for the linear probe hash table
// Field widths of the stream words and the result status codes.
// ----------------------------------------------------------------------------
package lph_pkg;

    // Width of a stored key; the value zero marks an empty slot.
    localparam int KEY_W  = 31;
    // Width of the reported slot field.
    localparam int SLOT_W = 4;
    // Width of the status field.
    localparam int STAT_W = 2;

    typedef logic [KEY_W-1:0] key_t;

    // Operation selector carried on the input tuser.
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } action_t;

    // Result status carried on the output tuser.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_KEY   = 2'd3
    } status_t;

endpackage

/* rtl/lph_ram.sv */
// ----------------------------------------------------------------------------
// lph_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/lph_hash.sv */
// ----------------------------------------------------------------------------
// lph_hash: home slot unit
// Reduces a key modulo the table size. A power-of-two size takes the low
// bits; any other size takes a multiply by a rounded-up reciprocal for the
// quotient, then a multiply and subtract for the remainder.
// ----------------------------------------------------------------------------
module lph_hash #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  lph_pkg::key_t                 key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] home
);

    localparam int  IDXW    = $clog2(TABLE_SIZE);
    localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    logic            done_reg;
    logic [IDXW-1:0] home_reg;

    assign done = done_reg;
    assign home = home_reg;

    if (IS_POW2) begin : g_mask
        // The home slot is simply the low bits of the key.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                home_reg <= key[IDXW-1:0];
            end
        end
    end else begin : g_recip
        // With the shift set to key width plus index width, the rounded-up
        // reciprocal gives the exact quotient for every key value.
        localparam int PROD_SH = lph_pkg::KEY_W + IDXW;
        localparam int QW      = 63 - PROD_SH;
        localparam logic [63:0] RECIP_FULL =
            ((64'd1 << PROD_SH) / 64'(TABLE_SIZE)) + 64'd1;
        localparam logic [31:0] RECIP  = RECIP_FULL[31:0];
        localparam logic [31:0] SIZE_W = 32'(TABLE_SIZE);

        logic          mul_reg;
        logic          sub_reg;
        lph_pkg::key_t key_hold_reg;
        logic [QW-1:0] quot_reg;
        logic [62:0]   prod;
        logic [31:0]   back;
        logic [31:0]   rem;

        // Quotient product, then the remainder by multiply and subtract.
        assign prod = 63'(key_hold_reg) * 63'(RECIP);
        assign back = 32'(quot_reg) * SIZE_W;
        assign rem  = {1'b0, key_hold_reg} - back;

        // Step sequencing: quotient, remainder, done.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_reg  <= 1'b0;
                sub_reg  <= 1'b0;
                done_reg <= 1'b0;
            end
            else
            begin
                mul_reg  <= start;
                sub_reg  <= mul_reg;
                done_reg <= sub_reg;
            end
        end

        // Key, quotient and remainder datapath.
        always_ff @(posedge clk)
        begin
            if (start)
            begin
                key_hold_reg <= key;
            end
            if (mul_reg)
            begin
                quot_reg <= prod[62:PROD_SH];
            end
            if (sub_reg)
            begin
                home_reg <= rem[IDXW-1:0];
            end
        end
    end

endmodule

/* rtl/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open-addressing hash table, linear probing
// Inserts or searches positive keys in a table held in one RAM. One probe
// sequencer reads one slot per cycle through a single key comparator.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata                       tuser
//  s_*      in   [30:0] key                  [0] action (0 insert, 1 search)
//  m_*      out  [3:0] slot                  [1:0] status
//
//  An item is accepted, hashed to its home slot, then probed from there over
//  1 to TABLE_SIZE slots through the one RAM read port, and its result is
//  handed to the output register. A zero key skips hashing and probing.
//  After reset a clearing pass writes every slot to empty, with s_tready
//  low. s_tready is high only while the sequencer is idle; a held output
//  word stalls only the final handoff.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
    parameter int TABLE_SIZE = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [31:0] s_tdata,   // [30:0] key, [31] zero
    input  logic       s_tuser,    // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [3:0] slot, [7:4] zero
    output logic [1:0] m_tuser     // [1:0] status
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDXW-1:0]          idx_reg, idx_next;
    logic [IDXW-1:0]          cnt_reg, cnt_next;
    lph_pkg::key_t            key_reg, key_next;
    lph_pkg::action_t         act_reg, act_next;
    logic [IDXW-1:0]          res_slot_reg, res_slot_next;
    lph_pkg::status_t         res_stat_reg, res_stat_next;
    logic                     out_valid_reg, out_valid_next;
    logic [lph_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    lph_pkg::status_t         out_stat_reg, out_stat_next;

    logic                     accept;
    lph_pkg::key_t            in_key;
    logic                     hash_start;
    logic                     hash_done;
    logic [IDXW-1:0]          hash_home;
    logic                     wr_en;
    logic [IDXW-1:0]          wr_addr;
    lph_pkg::key_t            wr_data;
    lph_pkg::key_t            rd_data;
    logic [IDXW-1:0]          idx_inc;
    logic                     slot_match;
    logic                     slot_empty;
    logic [31:0]              res_slot_ext;

    assign in_key     = s_tdata[lph_pkg::KEY_W-1:0];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign hash_start = accept && (in_key != '0);

    // Home slot unit.
    lph_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (in_key),
        .done  (hash_done),
        .home  (hash_home)
    );

    // Slot storage; the read address is the next probe index, so the registered read data belongs to the current probe.
    lph_ram #(
        .WIDTH (lph_pkg::KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    // Probe helpers: wrapping increment and the single key comparator.
    assign idx_inc      = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign slot_match   = (rd_data == key_reg);
    assign slot_empty   = (rd_data == '0);
    assign res_slot_ext = 32'(res_slot_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        act_next       = act_reg;
        res_slot_next  = res_slot_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_slot_next  = out_slot_reg;
        out_stat_next  = out_stat_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = key_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next = in_key;
                    act_next = lph_pkg::action_t'(s_tuser);
                    if (in_key == '0)
                    begin
                        res_slot_next = '0;
                        res_stat_next = lph_pkg::ST_BAD_KEY;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_home;
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (act_reg == lph_pkg::ACT_INSERT)
                begin
                    if (slot_empty)
                    begin
                        wr_en         = 1'b1;
                        res_slot_next = idx_reg;
                        res_stat_next = lph_pkg::ST_OK;
                        state_next    = S_DONE;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        res_slot_next = '0;
                        res_stat_next = lph_pkg::ST_FULL;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    if (slot_match)
                    begin
                        res_slot_next = idx_reg;
                        res_stat_next = lph_pkg::ST_OK;
                        state_next    = S_DONE;
                    end
                    else if (slot_empty || cnt_reg == LAST_IDX)
                    begin
                        res_slot_next = '0;
                        res_stat_next = lph_pkg::ST_NOT_FOUND;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = res_slot_ext[lph_pkg::SLOT_W-1:0];
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        act_reg      <= act_next;
        res_slot_reg <= res_slot_next;
        res_stat_reg <= res_stat_next;
        out_slot_reg <= out_slot_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_slot_reg};
    assign m_tuser  = out_stat_reg;

`ifndef SYNTHESIS
    // A search never modifies the table.
    a_search_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE && act_reg == lph_pkg::ACT_SEARCH) |-> !wr_en)
        else $error("table written during a search");

    // A zero key is rejected without hashing or probing.
    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_key == '0) |=>
            (state_reg == S_DONE && res_stat_reg == lph_pkg::ST_BAD_KEY))
        else $error("zero key not rejected");

    // Any non-ok result reports slot zero.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != lph_pkg::ST_OK) |-> (m_tdata[3:0] == 4'd0))
        else $error("nonzero slot with failing status");

    // An insert writes only the slot it found empty.
    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE && wr_en) |-> (slot_empty && wr_addr == idx_reg))
        else $error("insert wrote an occupied slot");
`endif

endmodule
